/* rtl/core/bol_pkg.sv */
// bol_pkg: shared types and constants of the bounded ordered list
// request/result structs, opcodes, status codes, cell commands and fsm states
// no dependencies
`default_nettype none

package bol_pkg;

    // list capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int RCNT_W   = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_POS   = 3'd3,
        OP_DUMP      = 3'd4
    } op_e_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CC_HOLD,
        CC_INS_FRONT,
        CC_INS_BACK,
        CC_REMOVE,
        CC_ROTATE
    } cell_cmd_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_DUMP
    } fsm_t;

    // request payload
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_t;

    // result payload
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value_res;
        logic [RCNT_W-1:0]        count;
        logic                     last;
    } res_t;

    // control broadcast to every cell
    typedef struct packed {
        cell_cmd_t                cmd;
        logic [IDX_W-1:0]         idx;
        logic [CNT_W-1:0]         cnt;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/bol_cell.sv */
// bol_cell: one storage cell of the list chain
// picks its next value from itself, its neighbors, the front cell or new data
// depends on bol_pkg
`default_nettype none

module bol_cell (
    input  wire logic                              aclk,
    input  wire bol_pkg::cell_ctrl_t               ctrl,
    input  wire logic [bol_pkg::IDX_W-1:0]         index,
    input  wire logic signed [bol_pkg::DATA_W-1:0] left_val,
    input  wire logic signed [bol_pkg::DATA_W-1:0] right_val,
    input  wire logic signed [bol_pkg::DATA_W-1:0] wrap_val,
    output logic signed [bol_pkg::DATA_W-1:0]      data
);

    logic signed [bol_pkg::DATA_W-1:0] data_reg;
    logic signed [bol_pkg::DATA_W-1:0] data_next;
    logic [bol_pkg::CNT_W-1:0]         pos;
    logic [bol_pkg::CNT_W-1:0]         pos_plus;

    assign pos      = bol_pkg::CNT_W'(index);
    assign pos_plus = pos + bol_pkg::CNT_W'(1);

    // select next cell content
    always_comb begin
        data_next = data_reg;
        unique case (ctrl.cmd)
            bol_pkg::CC_HOLD: begin
                data_next = data_reg;
            end
            bol_pkg::CC_INS_FRONT: begin
                data_next = (index == '0) ? ctrl.value : left_val;
            end
            bol_pkg::CC_INS_BACK: begin
                if (pos == ctrl.cnt) begin
                    data_next = ctrl.value;
                end
            end
            bol_pkg::CC_REMOVE: begin
                if (index >= ctrl.idx) begin
                    data_next = right_val;
                end
            end
            bol_pkg::CC_ROTATE: begin
                if (pos_plus == ctrl.cnt) begin
                    data_next = wrap_val;
                end else if (pos_plus < ctrl.cnt) begin
                    data_next = right_val;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    // cell storage
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* rtl/core/bounded_ordered_list.sv */
// bounded_ordered_list: top level, request decode, dump sequencer, result register
// instantiates a chain of bol_cell, one per entry
// depends on bol_pkg and bol_cell
`default_nettype none

// A bounded, ordered list of up to 16 signed 32-bit values held in a chain of
// cells, front entry in cell 0. Insert front, insert back, remove front and
// remove at position shift the whole chain in the cycle the request is
// accepted, unless refused as full, empty or bad position; one result
// follows. A dump rotates the chain by one cell per result, so
// the front cell always holds the next value to emit, and after the last one
// the list is back in its original order. No new request is taken during a
// dump. Results leave through a single result register, and a request is only
// taken when that register is empty or its result is accepted in the same
// cycle, so a result that waits for m_ready also holds off s_ready. Entry
// contents are not cleared at reset; only the entry count is.
module bounded_ordered_list (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bol_pkg::req_t s_req,
    output logic               m_valid,
    input  wire logic          m_ready,
    output bol_pkg::res_t      m_res
);

    bol_pkg::fsm_t             state_reg, state_next;
    logic [bol_pkg::CNT_W-1:0] count_reg, count_next;
    logic [bol_pkg::CNT_W-1:0] dump_left_reg, dump_left_next;
    logic                      m_valid_reg, m_valid_next;
    bol_pkg::res_t             m_res_reg, m_res_next;
    bol_pkg::cell_ctrl_t       ctrl;
    logic                      out_free;
    logic                      load;
    logic [bol_pkg::CMP_W-1:0] pos_ext;
    logic [bol_pkg::CMP_W-1:0] cnt_ext;
    logic [bol_pkg::POS_W-1:0] pos_m1;

    logic signed [bol_pkg::DATA_W-1:0] cell_data [bol_pkg::CAPACITY];

    assign out_free = !m_valid_reg || m_ready;
    assign pos_ext  = bol_pkg::CMP_W'(s_req.position);
    assign cnt_ext  = bol_pkg::CMP_W'(count_reg);
    assign pos_m1   = s_req.position - bol_pkg::POS_W'(1);

    // decode, list bookkeeping and dump sequencing
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        dump_left_next = dump_left_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_res_next     = m_res_reg;
        load           = 1'b0;
        ctrl.cmd       = bol_pkg::CC_HOLD;
        ctrl.idx       = '0;
        ctrl.cnt       = count_reg;
        ctrl.value     = s_req.value;

        unique case (state_reg)
            bol_pkg::FSM_IDLE: begin
                if (s_valid && out_free) begin
                    load                 = 1'b1;
                    m_res_next.status    = bol_pkg::ST_OK;
                    m_res_next.value_res = '0;
                    m_res_next.last      = 1'b1;
                    case (s_req.op)
                        bol_pkg::OP_INS_FRONT, bol_pkg::OP_INS_BACK: begin
                            if (count_reg >= bol_pkg::CNT_W'(bol_pkg::CAPACITY)) begin
                                m_res_next.status = bol_pkg::ST_FULL;
                            end else begin
                                ctrl.cmd   = (s_req.op == bol_pkg::OP_INS_FRONT) ?
                                             bol_pkg::CC_INS_FRONT : bol_pkg::CC_INS_BACK;
                                count_next = count_reg + bol_pkg::CNT_W'(1);
                            end
                        end
                        bol_pkg::OP_REM_FRONT: begin
                            if (count_reg == '0) begin
                                m_res_next.status = bol_pkg::ST_EMPTY;
                            end else begin
                                ctrl.cmd   = bol_pkg::CC_REMOVE;
                                ctrl.idx   = '0;
                                count_next = count_reg - bol_pkg::CNT_W'(1);
                            end
                        end
                        bol_pkg::OP_REM_POS: begin
                            if (count_reg == '0) begin
                                m_res_next.status = bol_pkg::ST_EMPTY;
                            end else if (s_req.position == '0 || pos_ext > cnt_ext) begin
                                m_res_next.status = bol_pkg::ST_BADPOS;
                            end else begin
                                ctrl.cmd   = bol_pkg::CC_REMOVE;
                                ctrl.idx   = bol_pkg::IDX_W'(pos_m1);
                                count_next = count_reg - bol_pkg::CNT_W'(1);
                            end
                        end
                        bol_pkg::OP_DUMP: begin
                            if (count_reg == '0) begin
                                m_res_next.status = bol_pkg::ST_EMPTY;
                            end else begin
                                // no result yet, the sequencer emits them
                                load           = 1'b0;
                                state_next     = bol_pkg::FSM_DUMP;
                                dump_left_next = count_reg;
                            end
                        end
                        default: begin
                            m_res_next.status = bol_pkg::ST_OK;
                        end
                    endcase
                    if (load) begin
                        m_valid_next     = 1'b1;
                        m_res_next.count = bol_pkg::RCNT_W'(count_next);
                    end
                end
            end
            bol_pkg::FSM_DUMP: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_res_next.status    = bol_pkg::ST_OK;
                    m_res_next.value_res = cell_data[0];
                    m_res_next.count     = bol_pkg::RCNT_W'(count_reg);
                    m_res_next.last      = (dump_left_reg == bol_pkg::CNT_W'(1));
                    ctrl.cmd             = bol_pkg::CC_ROTATE;
                    dump_left_next       = dump_left_reg - bol_pkg::CNT_W'(1);
                    if (dump_left_reg == bol_pkg::CNT_W'(1)) begin
                        state_next = bol_pkg::FSM_IDLE;
                    end
                end
            end
            default: begin
                state_next = bol_pkg::FSM_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bol_pkg::FSM_IDLE;
            count_reg     <= '0;
            dump_left_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_left_reg <= dump_left_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    // chain of cells
    for (genvar i = 0; i < bol_pkg::CAPACITY; i++) begin : g_cell
        logic signed [bol_pkg::DATA_W-1:0] left_v;
        logic signed [bol_pkg::DATA_W-1:0] right_v;
        if (i == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = cell_data[i-1];
        end
        if (i == bol_pkg::CAPACITY - 1) begin : g_last
            assign right_v = cell_data[i];
        end else begin : g_mid_r
            assign right_v = cell_data[i+1];
        end
        bol_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .index     (bol_pkg::IDX_W'(i)),
            .left_val  (left_v),
            .right_val (right_v),
            .wrap_val  (cell_data[0]),
            .data      (cell_data[i])
        );
    end

    assign s_ready = (state_reg == bol_pkg::FSM_IDLE) && out_free;
    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // the entry count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= bol_pkg::CNT_W'(bol_pkg::CAPACITY))
        else $error("entry count above capacity");

    // a dump leaves the count untouched
    a_dump_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bol_pkg::FSM_DUMP) |=> (count_reg == $past(count_reg)))
        else $error("count changed during dump");

    // a result without last only comes out of a running dump
    a_nonlast_dump: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_res_reg.last) |-> (state_reg == bol_pkg::FSM_DUMP))
        else $error("non-final result outside dump");

    // every accepted request yields a result or starts a dump
    a_req_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (m_valid_reg || state_reg == bol_pkg::FSM_DUMP))
        else $error("request dropped");

    // the dump counter is nonzero while dumping
    a_dump_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bol_pkg::FSM_DUMP) |-> (dump_left_reg != '0))
        else $error("dump counter empty during dump");

endmodule

`default_nettype wire

/* dv/tb_bounded_ordered_list.sv */
// tb_bounded_ordered_list: self-checking testbench for the bounded ordered list
// queue-fed request driver, result monitor and a list predictor built on a queue
// depends on bol_pkg and bounded_ordered_list
`default_nettype none

module tb_bounded_ordered_list;

    // opcodes the block leaves undefined
    localparam logic [bol_pkg::OP_W-1:0] UNUSED_OP_FIRST = 3'd5;
    localparam logic [bol_pkg::OP_W-1:0] UNUSED_OP_MID   = 3'd6;
    localparam logic [bol_pkg::OP_W-1:0] UNUSED_OP_LAST  = 3'd7;
    localparam int                       RANDOM_REQS     = 350;
    localparam int                       LONG_HOLD       = 300;
    localparam int                       TAIL_CYCLES     = 40;

    typedef struct packed {
        logic          drain;
        bol_pkg::req_t req;
    } pending_req_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    bol_pkg::req_t  s_req   = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    bol_pkg::res_t  m_res;

    pending_req_t                      pending_reqs[$];
    bol_pkg::res_t                     expected_results[$];
    logic signed [bol_pkg::DATA_W-1:0] list_cells[$];

    logic req_fire = 1'b0;
    logic res_fire = 1'b0;
    int   send_gap = 0;
    int   rcv_wait = 0;
    int   long_hold = 0;
    bit   hold_done = 0;
    int   sent_count = 0;
    int   results_seen = 0;
    int   fail_count = 0;
    int   dump_count = 0;
    int   full_seen = 0;
    int   empty_seen = 0;
    int   badpos_seen = 0;
    int   gen_count = 0;

    bounded_ordered_list DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    always #10 aclk = ~aclk;

    // one expected result, count taken from the list after the operation
    function automatic void push_expected(input logic [1:0] status,
                                          input logic signed [bol_pkg::DATA_W-1:0] val,
                                          input logic last);
        bol_pkg::res_t rsp;
        rsp.status    = status;
        rsp.value_res = val;
        rsp.count     = bol_pkg::RCNT_W'(list_cells.size());
        rsp.last      = last;
        expected_results.push_back(rsp);
    endfunction

    // list behavior for one accepted request
    function automatic void predict_list_op(input bol_pkg::req_t r);
        int k;
        case (r.op)
            bol_pkg::OP_INS_FRONT, bol_pkg::OP_INS_BACK: begin
                if (list_cells.size() >= bol_pkg::CAPACITY) begin
                    push_expected(bol_pkg::ST_FULL, '0, 1'b1);
                end else begin
                    if (r.op == bol_pkg::OP_INS_FRONT)
                        list_cells.push_front(r.value);
                    else
                        list_cells.push_back(r.value);
                    push_expected(bol_pkg::ST_OK, '0, 1'b1);
                end
            end
            bol_pkg::OP_REM_FRONT: begin
                if (list_cells.size() == 0) begin
                    push_expected(bol_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    void'(list_cells.pop_front());
                    push_expected(bol_pkg::ST_OK, '0, 1'b1);
                end
            end
            bol_pkg::OP_REM_POS: begin
                // empty check wins over the position check
                if (list_cells.size() == 0) begin
                    push_expected(bol_pkg::ST_EMPTY, '0, 1'b1);
                end else if (r.position == 0 || int'(r.position) > list_cells.size()) begin
                    push_expected(bol_pkg::ST_BADPOS, '0, 1'b1);
                end else begin
                    list_cells.delete(int'(r.position) - 1);
                    push_expected(bol_pkg::ST_OK, '0, 1'b1);
                end
            end
            bol_pkg::OP_DUMP: begin
                dump_count++;
                if (list_cells.size() == 0) begin
                    push_expected(bol_pkg::ST_EMPTY, '0, 1'b1);
                end else begin
                    for (k = 0; k < list_cells.size(); k++)
                        push_expected(bol_pkg::ST_OK, list_cells[k],
                                      k == list_cells.size() - 1);
                end
            end
            default: begin
                push_expected(bol_pkg::ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    // queue a request and track the list length it leaves behind
    task automatic add_req(input logic [bol_pkg::OP_W-1:0] op,
                           input logic signed [bol_pkg::DATA_W-1:0] val,
                           input logic [bol_pkg::POS_W-1:0] pos);
        pending_req_t p;
        p.drain        = 1'b0;
        p.req.op       = op;
        p.req.value    = val;
        p.req.position = pos;
        pending_reqs.push_back(p);
        case (op)
            bol_pkg::OP_INS_FRONT, bol_pkg::OP_INS_BACK:
                if (gen_count < bol_pkg::CAPACITY) gen_count++;
            bol_pkg::OP_REM_FRONT: if (gen_count > 0) gen_count--;
            bol_pkg::OP_REM_POS: if (gen_count > 0 && pos >= 1 && pos <= gen_count) gen_count--;
            default: ;
        endcase
    endtask

    // random values with the extremes mixed in
    function automatic logic signed [bol_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [bol_pkg::OP_W-1:0] pick_insert();
        return $urandom_range(0, 1) ? bol_pkg::OP_INS_FRONT : bol_pkg::OP_INS_BACK;
    endfunction

    // random position over the whole field
    function automatic logic [bol_pkg::POS_W-1:0] pick_pos();
        return bol_pkg::POS_W'($urandom_range(0, 31));
    endfunction

    // request driver, changes inputs on the falling edge
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || req_fire)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].drain || expected_results.size() == 0)) begin
                s_valid <= 1'b1;
                s_req   <= pending_reqs[0].req;
                void'(pending_reqs.pop_front());
                sent_count++;
                // every so often a burst with no gaps
                send_gap <= ((sent_count % 60) >= 45) ? 0 : $urandom_range(0, 3);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: per-result stall plus one long hold-off
    always @(negedge aclk) begin
        if (aresetn) begin
            if (res_fire)
                rcv_wait = ((results_seen % 80) >= 60) ? 0 : $urandom_range(0, 3);
            if (!hold_done && sent_count >= 100) begin
                long_hold = LONG_HOLD;
                hold_done = 1;
            end
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        req_fire <= aresetn && s_valid && s_ready;
        res_fire <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready)
            predict_list_op(s_req);
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            case (m_res.status)
                bol_pkg::ST_FULL:   full_seen++;
                bol_pkg::ST_EMPTY:  empty_seen++;
                bol_pkg::ST_BADPOS: badpos_seen++;
                default: ;
            endcase
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d value_res %0d count %0d last %0d",
                       m_res.status, m_res.value_res, m_res.count, m_res.last);
                fail_count++;
            end else begin
                if (m_res.status !== expected_results[0].status) begin
                    $error("status: expected %0d, actual %0d",
                           expected_results[0].status, m_res.status);
                    fail_count++;
                end
                if (m_res.value_res !== expected_results[0].value_res) begin
                    $error("value_res: expected %0d, actual %0d",
                           expected_results[0].value_res, m_res.value_res);
                    fail_count++;
                end
                if (m_res.count !== expected_results[0].count) begin
                    $error("count: expected %0d, actual %0d",
                           expected_results[0].count, m_res.count);
                    fail_count++;
                end
                if (m_res.last !== expected_results[0].last) begin
                    $error("last: expected %0d, actual %0d",
                           expected_results[0].last, m_res.last);
                    fail_count++;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int kind;
        int n;
        int w;
        int total;
        logic [bol_pkg::POS_W-1:0] p;

        // directed: empty list corner cases and undefined opcodes
        add_req(bol_pkg::OP_DUMP, pick_value(), 5'd0);
        add_req(bol_pkg::OP_REM_FRONT, pick_value(), 5'd1);
        add_req(bol_pkg::OP_REM_POS, pick_value(), 5'd0);
        add_req(bol_pkg::OP_REM_POS, pick_value(), 5'd31);
        add_req(UNUSED_OP_FIRST, 32'h7fff_ffff, 5'd31);
        add_req(UNUSED_OP_MID, 32'h8000_0000, 5'd0);
        add_req(UNUSED_OP_LAST, 32'hffff_ffff, 5'd16);
        // directed: extreme values, bad positions, dump, removes
        add_req(bol_pkg::OP_INS_FRONT, 32'h8000_0000, 5'd0);
        add_req(bol_pkg::OP_INS_BACK, 32'h7fff_ffff, 5'd31);
        add_req(bol_pkg::OP_INS_FRONT, 32'h0000_0000, 5'd0);
        add_req(bol_pkg::OP_INS_BACK, 32'hffff_ffff, 5'd0);
        add_req(bol_pkg::OP_REM_POS, pick_value(), 5'd0);
        add_req(bol_pkg::OP_REM_POS, pick_value(), 5'd5);
        add_req(bol_pkg::OP_REM_POS, pick_value(), 5'd31);
        add_req(bol_pkg::OP_DUMP, pick_value(), 5'd0);
        add_req(bol_pkg::OP_REM_POS, pick_value(), 5'd4);
        add_req(bol_pkg::OP_REM_POS, pick_value(), 5'd2);
        add_req(bol_pkg::OP_DUMP, pick_value(), 5'd0);
        add_req(bol_pkg::OP_REM_POS, pick_value(), 5'd1);
        // removing the only entry empties the list
        add_req(bol_pkg::OP_REM_FRONT, pick_value(), 5'd0);
        add_req(bol_pkg::OP_DUMP, pick_value(), 5'd0);

        // random episodes: fill to full, drain to empty, mixed traffic
        total = pending_reqs.size() + RANDOM_REQS;
        while (pending_reqs.size() < total) begin
            kind = $urandom_range(0, 9);
            if (kind <= 1) begin
                while (gen_count < bol_pkg::CAPACITY)
                    add_req(pick_insert(), pick_value(), pick_pos());
                n = $urandom_range(1, 2);
                repeat (n) add_req(pick_insert(), pick_value(), pick_pos());
                add_req(bol_pkg::OP_DUMP, pick_value(), pick_pos());
                if ($urandom_range(0, 1))
                    add_req(bol_pkg::OP_REM_POS, pick_value(),
                            bol_pkg::POS_W'(bol_pkg::CAPACITY));
            end else if (kind == 2) begin
                while (gen_count > 0) begin
                    if ($urandom_range(0, 1))
                        add_req(bol_pkg::OP_REM_FRONT, pick_value(), pick_pos());
                    else
                        add_req(bol_pkg::OP_REM_POS, pick_value(),
                                bol_pkg::POS_W'($urandom_range(1, gen_count)));
                end
                add_req($urandom_range(0, 1) ? bol_pkg::OP_REM_FRONT : bol_pkg::OP_REM_POS,
                        pick_value(), pick_pos());
                if ($urandom_range(0, 1))
                    add_req(bol_pkg::OP_DUMP, pick_value(), pick_pos());
            end else begin
                repeat (10) begin
                    w = $urandom_range(0, 99);
                    if (w < 40) begin
                        add_req(pick_insert(), pick_value(), pick_pos());
                    end else if (w < 55) begin
                        add_req(bol_pkg::OP_REM_FRONT, pick_value(), pick_pos());
                    end else if (w < 75) begin
                        p = (gen_count > 0) ? bol_pkg::POS_W'($urandom_range(1, gen_count))
                                            : pick_pos();
                        add_req(bol_pkg::OP_REM_POS, pick_value(), p);
                    end else if (w < 85) begin
                        add_req(bol_pkg::OP_DUMP, pick_value(), pick_pos());
                    end else if (w < 92) begin
                        add_req(bol_pkg::OP_REM_POS, pick_value(), pick_pos());
                    end else begin
                        add_req(bol_pkg::OP_W'($urandom_range(UNUSED_OP_FIRST, UNUSED_OP_LAST)),
                                pick_value(), pick_pos());
                    end
                end
            end
        end
        // one request waits for the block to drain completely
        pending_reqs[pending_reqs.size() / 2 + 40].drain = 1'b1;

        // reset
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait for all requests, then all results, then a quiet tail
        while (pending_reqs.size() > 0 || s_valid) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests, %0d results, %0d dumps", sent_count, results_seen,
                 dump_count);
        $display("status mix: %0d full, %0d empty, %0d bad position", full_seen, empty_seen,
                 badpos_seen);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
